// ----- rtl/core/space_vector_pwm_duty_macros.svh -----
// Assertion macros for the space-vector PWM duty block.
// Both expect clk_i in the scope of use; SVPD_ASSERT also expects rst_ni.
`ifndef SPACE_VECTOR_PWM_DUTY_MACROS_SVH
`define SPACE_VECTOR_PWM_DUTY_MACROS_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define SVPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define SVPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SVPD_ASSERT(lbl, prop, msg)
`define SVPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/svpd_pkg.sv -----
package svpd_pkg;

  // sqrt(3) in Q30 and pi/2 in Q30
  localparam logic signed [31:0] SQRT3_Q30   = 32'sd1859775393;
  localparam longint unsigned    HALF_PI_Q30 = 64'd1686629713;

  localparam logic [2:0] SECTOR_MIN = 3'd1;
  localparam logic [2:0] SECTOR_MAX = 3'd6;

  // {beta > 0, beta^2 > 3 alpha^2, alpha > 0} to sector number
  function automatic logic [2:0] sector_of_key(input logic [2:0] key);
    logic [2:0] s;
    case (key)
      3'd0:    s = 3'd4;
      3'd1:    s = 3'd6;
      3'd2:    s = 3'd5;
      3'd3:    s = 3'd5;
      3'd4:    s = 3'd3;
      3'd5:    s = 3'd1;
      3'd6:    s = 3'd2;
      default: s = 3'd2;
    endcase
    return s;
  endfunction

  // sin(k*60deg) = sin3_of(k) * sqrt(3)/2
  function automatic logic signed [1:0] sin3_of(input logic [2:0] k);
    logic signed [1:0] c;
    case (k)
      3'd1, 3'd2: c = 2'sd1;
      3'd4, 3'd5: c = -2'sd1;
      default:    c = 2'sd0;
    endcase
    return c;
  endfunction

  // cos(k*60deg) = cos2_of(k) / 2
  function automatic logic signed [2:0] cos2_of(input logic [2:0] k);
    logic signed [2:0] c;
    case (k)
      3'd0:       c = 3'sd2;
      3'd1, 3'd5: c = 3'sd1;
      3'd2, 3'd4: c = -3'sd1;
      3'd3:       c = -3'sd2;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

  // switching state of active vector row, {u, v, w}
  function automatic logic [2:0] vec_on_of(input logic [2:0] row);
    logic [2:0] v;
    case (row)
      3'd0:    v = 3'b100;
      3'd1:    v = 3'b110;
      3'd2:    v = 3'b010;
      3'd3:    v = 3'b011;
      3'd4:    v = 3'b001;
      3'd5:    v = 3'b101;
      default: v = 3'b000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/svpd_if.sv -----
// Command word channel
interface svpd_in_if #(
  parameter int ANGLE_BITS = 16,
  parameter int DATA_BITS  = 16
) ();
  logic                        valid;
  logic                        ready;
  logic [ANGLE_BITS-1:0]       angle;
  logic signed [DATA_BITS-1:0] d_cmd;
  logic signed [DATA_BITS-1:0] q_cmd;

  modport source (output valid, angle, d_cmd, q_cmd, input ready);
  modport sink   (input valid, angle, d_cmd, q_cmd, output ready);
endinterface

// Duty word channel
interface svpd_out_if #(
  parameter int DATA_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] duty_u;
  logic [DATA_BITS-1:0] duty_v;
  logic [DATA_BITS-1:0] duty_w;
  logic [2:0]           sector_num;
  logic                 overmodulated;

  modport source (output valid, duty_u, duty_v, duty_w, sector_num, overmodulated,
                  input ready);
  modport sink   (input valid, duty_u, duty_v, duty_w, sector_num, overmodulated,
                  output ready);
endinterface

// ----- rtl/core/svpd_sine_lut.sv -----
`include "space_vector_pwm_duty_macros.svh"

module svpd_sine_lut #(
  parameter int ANGLE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int DATA_BITS        = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [ANGLE_BITS-1:0]       angle_i,
  input  logic signed [DATA_BITS-1:0] d_i,
  input  logic signed [DATA_BITS-1:0] q_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [DATA_BITS:0]   sin_o,
  output logic signed [DATA_BITS:0]   cos_o,
  output logic signed [DATA_BITS-1:0] d_o,
  output logic signed [DATA_BITS-1:0] q_o
);
  import svpd_pkg::*;

  localparam int F  = DATA_BITS - 1;
  localparam int QB = ANGLE_BITS - 2;
  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = QB + IW + 1;
  localparam int NS = 2;

  // quarter-wave table, built at elaboration: 9-term Taylor series in Q30,
  // rounded to Q(F)
  logic [DATA_BITS-1:0] rom [SINE_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint unsigned X  = (HALF_PI_Q30 * gi) / SINE_TABLE_DEPTH;
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X  * X2) >> 30) / 6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / 156;
    localparam longint unsigned T7 = ((T6 * X2) >> 30) / 210;
    localparam longint unsigned T8 = ((T7 * X2) >> 30) / 272;
    localparam longint S_RAW = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                             + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7)
                             + longint'(T8);
    localparam longint S_POS = (S_RAW < 0) ? 64'sd0 : S_RAW;
    localparam longint ENT   = (S_POS + (longint'(1) << (29 - F))) >>> (30 - F);
    assign rom[gi] = DATA_BITS'(ENT);
  end

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic [NS-1:0] v_in;

  always_comb begin
    en[NS] = ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end
  assign v_in    = {v_q[NS-2:0], valid_i};
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v_q[i] <= v_in[i];
      end
    end
  end

  // stage 1: table index, mirrored on odd quadrants; cosine is one quadrant on
  logic [1:0]    quad_s, quad_c;
  logic [PW-1:0] scaled;
  logic [IW:0]   idx_raw;
  logic [IW-1:0] idx, idx_mir;

  assign quad_s  = angle_i[ANGLE_BITS-1 -: 2];
  assign quad_c  = quad_s + 2'd1;
  assign scaled  = PW'(angle_i[QB-1:0]) * PW'(SINE_TABLE_DEPTH) + (PW'(1) << (QB - 1));
  assign idx_raw = (IW + 1)'(scaled >> QB);
  assign idx     = (idx_raw > (IW + 1)'(SINE_TABLE_DEPTH)) ? IW'(SINE_TABLE_DEPTH)
                                                          : idx_raw[IW-1:0];
  assign idx_mir = IW'(SINE_TABLE_DEPTH) - idx;

  logic [IW-1:0]               idx_s_q, idx_c_q;
  logic                        neg_s_q, neg_c_q;
  logic signed [DATA_BITS-1:0] d1_q, q1_q;

  // stage 2: table read and quadrant sign
  logic signed [DATA_BITS:0]   mag_s, mag_c;
  logic signed [DATA_BITS:0]   sin_q, cos_q;
  logic signed [DATA_BITS-1:0] d2_q, q2_q;

  assign mag_s = $signed({1'b0, rom[idx_s_q]});
  assign mag_c = $signed({1'b0, rom[idx_c_q]});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      idx_s_q <= quad_s[0] ? idx_mir : idx;
      idx_c_q <= quad_c[0] ? idx_mir : idx;
      neg_s_q <= quad_s[1];
      neg_c_q <= quad_c[1];
      d1_q    <= d_i;
      q1_q    <= q_i;
    end
    if (en[1]) begin
      sin_q <= neg_s_q ? -mag_s : mag_s;
      cos_q <= neg_c_q ? -mag_c : mag_c;
      d2_q  <= d1_q;
      q2_q  <= q1_q;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
  assign d_o   = d2_q;
  assign q_o   = q2_q;

  // sine and cosine of one angle are never both zero
  `SVPD_ASSERT(a_sincos_nonzero, valid_o |-> (sin_o != 0 || cos_o != 0), "sin and cos both zero")

endmodule

// ----- rtl/core/svpd_park.sv -----
module svpd_park #(
  parameter int DATA_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [DATA_BITS:0]   sin_i,
  input  logic signed [DATA_BITS:0]   cos_i,
  input  logic signed [DATA_BITS-1:0] d_i,
  input  logic signed [DATA_BITS-1:0] q_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [DATA_BITS+1:0] alpha_o,
  output logic signed [DATA_BITS+1:0] beta_o
);
  localparam int F   = DATA_BITS - 1;
  localparam int AW  = DATA_BITS + 2;
  localparam int PRW = 2 * DATA_BITS + 1;
  localparam int NS  = 3;
  localparam logic signed [PRW:0] HALF = (PRW + 1)'(1) <<< (F - 1);

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic [NS-1:0] v_in;

  always_comb begin
    en[NS] = ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end
  assign v_in    = {v_q[NS-2:0], valid_i};
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v_q[i] <= v_in[i];
      end
    end
  end

  // commands are already within [-1, 1] at this width, so no clamp is built
  logic signed [PRW-1:0] dc_d, qs_d, ds_d, qc_d;
  logic signed [PRW-1:0] dc_q, qs_q, ds_q, qc_q;
  logic signed [PRW:0]   xa_q, xb_q;
  logic signed [PRW:0]   ra_d, rb_d;
  logic signed [AW-1:0]  alpha_q, beta_q;

  assign dc_d = d_i * cos_i;
  assign qs_d = q_i * sin_i;
  assign ds_d = d_i * sin_i;
  assign qc_d = q_i * cos_i;

  // Q(2F) to Q(F), half away from zero: negatives add one less before the floor
  assign ra_d = (xa_q + (xa_q[PRW] ? HALF - 1 : HALF)) >>> F;
  assign rb_d = (xb_q + (xb_q[PRW] ? HALF - 1 : HALF)) >>> F;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dc_q <= dc_d;
      qs_q <= qs_d;
      ds_q <= ds_d;
      qc_q <= qc_d;
    end
    if (en[1]) begin
      xa_q <= (PRW + 1)'(dc_q) - (PRW + 1)'(qs_q);
      xb_q <= (PRW + 1)'(ds_q) + (PRW + 1)'(qc_q);
    end
    if (en[2]) begin
      alpha_q <= AW'(ra_d);
      beta_q  <= AW'(rb_d);
    end
  end

  assign alpha_o = alpha_q;
  assign beta_o  = beta_q;

endmodule

// ----- rtl/core/svpd_sector.sv -----
module svpd_sector #(
  parameter int DATA_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [DATA_BITS+1:0]  alpha_i,
  input  logic signed [DATA_BITS+1:0]  beta_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [2:0]                   sector_o,
  output logic signed [DATA_BITS+33:0] p_o,
  output logic signed [DATA_BITS+1:0]  beta_o
);
  import svpd_pkg::*;

  localparam int AW  = DATA_BITS + 2;
  localparam int PW  = AW + 32;
  localparam int SQW = 2 * AW + 2;
  localparam int NS  = 2;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic [NS-1:0] v_in;

  always_comb begin
    en[NS] = ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end
  assign v_in    = {v_q[NS-2:0], valid_i};
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v_q[i] <= v_in[i];
      end
    end
  end

  // stage 1: squares and alpha*sqrt(3)
  logic signed [2*AW-1:0] a2_d, b2_d;
  logic signed [PW-1:0]   p_d;
  logic [2*AW-1:0]        a2_q, b2_q;
  logic signed [PW-1:0]   p1_q;
  logic signed [AW-1:0]   beta1_q;
  logic                   a_pos_q, b_pos_q;

  assign a2_d = alpha_i * alpha_i;
  assign b2_d = beta_i * beta_i;
  assign p_d  = alpha_i * SQRT3_Q30;

  // stage 2: exact compare beta^2 > 3 alpha^2, sector lookup
  logic [SQW-1:0] a3;
  logic [2:0]     key;

  assign a3  = SQW'(a2_q) + (SQW'(a2_q) << 1);
  assign key = {b_pos_q, SQW'(b2_q) > a3, a_pos_q};

  logic [2:0]           sector_q;
  logic signed [PW-1:0] p2_q;
  logic signed [AW-1:0] beta2_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a2_q    <= $unsigned(a2_d);
      b2_q    <= $unsigned(b2_d);
      p1_q    <= p_d;
      beta1_q <= beta_i;
      a_pos_q <= !alpha_i[AW-1] && (alpha_i != '0);
      b_pos_q <= !beta_i[AW-1] && (beta_i != '0);
    end
    if (en[1]) begin
      sector_q <= sector_of_key(key);
      p2_q     <= p1_q;
      beta2_q  <= beta1_q;
    end
  end

  assign sector_o = sector_q;
  assign p_o      = p2_q;
  assign beta_o   = beta2_q;

endmodule

// ----- rtl/core/svpd_duty.sv -----
module svpd_duty #(
  parameter int DATA_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [2:0]                   sector_i,
  input  logic signed [DATA_BITS+33:0] p_i,
  input  logic signed [DATA_BITS+1:0]  beta_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [DATA_BITS-1:0]         duty_u_o,
  output logic [DATA_BITS-1:0]         duty_v_o,
  output logic [DATA_BITS-1:0]         duty_w_o,
  output logic [2:0]                   sector_o,
  output logic                         ovm_o
);
  import svpd_pkg::*;

  localparam int F  = DATA_BITS - 1;
  localparam int TW = DATA_BITS + 37;
  localparam int NS = 4;
  localparam logic signed [TW-1:0] ONE_H     = TW'(1) <<< (F + 31);
  localparam logic signed [TW-1:0] TOP       = TW'(1) <<< (F + 32);
  localparam logic signed [TW-1:0] HALF32    = TW'(1) <<< 31;
  localparam logic [DATA_BITS-1:0] DUTY_FULL = DATA_BITS'(1) << F;

  // coefficient in {-2, -1, 0, 1, 2}: shift and negate, no multiplier
  function automatic logic signed [TW-1:0] mul_small(input logic signed [2:0]    c,
                                                     input logic signed [TW-1:0] x);
    logic signed [TW-1:0] r;
    case (c)
      3'sd1:   r = x;
      3'sd2:   r = x <<< 1;
      -3'sd1:  r = -x;
      -3'sd2:  r = -(x <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic [NS-1:0] v_in;

  always_comb begin
    en[NS] = ready_i;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end
  assign v_in    = {v_q[NS-2:0], valid_i};
  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v_q[i] <= v_in[i];
      end
    end
  end

  // stage 1: active-vector times, twice over in Q(F+30)
  logic [2:0]           km, kn;
  logic signed [TW-1:0] p_ext, b30;
  logic signed [TW-1:0] tm_d, tn_d;

  assign km    = (sector_i == SECTOR_MAX) ? 3'd0 : sector_i;
  assign kn    = sector_i - 3'd1;
  assign p_ext = TW'(p_i);
  assign b30   = TW'(beta_i) <<< 30;
  assign tm_d  = mul_small(3'(sin3_of(km)), p_ext) - mul_small(cos2_of(km), b30);
  assign tn_d  = mul_small(cos2_of(kn), b30) - mul_small(3'(sin3_of(kn)), p_ext);

  logic signed [TW-1:0] tm1_q, tn1_q;
  logic [2:0]           on_m1_q, on_n1_q, sec1_q;

  // stage 2: zero time
  logic signed [TW-1:0] tm2_q, tn2_q, t0_q;
  logic [2:0]           on_m2_q, on_n2_q, sec2_q;

  // stage 3: twice the phase duty, per phase {u, v, w}
  logic signed [TW-1:0] twice_d [3];
  logic signed [TW-1:0] twice_q [3];
  logic [2:0]           sec3_q;
  logic                 ovm3_q;

  always_comb begin
    for (int ph = 0; ph < 3; ph++) begin
      twice_d[ph] = (((on_m2_q[2-ph] ? tm2_q : '0) + (on_n2_q[2-ph] ? tn2_q : '0)) <<< 1)
                    + t0_q;
    end
  end

  // stage 4: clamp to [0, 1] and round half up
  logic [DATA_BITS-1:0] duty_d [3];
  logic [DATA_BITS-1:0] duty_q [3];
  logic [2:0]           sec4_q;
  logic                 ovm4_q;

  always_comb begin
    for (int ph = 0; ph < 3; ph++) begin
      if (twice_q[ph] <= 0) begin
        duty_d[ph] = '0;
      end else if (twice_q[ph] >= TOP) begin
        duty_d[ph] = DUTY_FULL;
      end else begin
        duty_d[ph] = DATA_BITS'((twice_q[ph] + HALF32) >>> 32);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tm1_q   <= tm_d;
      tn1_q   <= tn_d;
      on_m1_q <= vec_on_of(sector_i - 3'd1);
      on_n1_q <= vec_on_of(km);
      sec1_q  <= sector_i;
    end
    if (en[1]) begin
      tm2_q   <= tm1_q;
      tn2_q   <= tn1_q;
      t0_q    <= ONE_H - tm1_q - tn1_q;
      on_m2_q <= on_m1_q;
      on_n2_q <= on_n1_q;
      sec2_q  <= sec1_q;
    end
    if (en[2]) begin
      for (int ph = 0; ph < 3; ph++) begin
        twice_q[ph] <= twice_d[ph];
      end
      sec3_q <= sec2_q;
      ovm3_q <= t0_q[TW-1];
    end
    if (en[3]) begin
      for (int ph = 0; ph < 3; ph++) begin
        duty_q[ph] <= duty_d[ph];
      end
      sec4_q <= sec3_q;
      ovm4_q <= ovm3_q;
    end
  end

  assign duty_u_o = duty_q[0];
  assign duty_v_o = duty_q[1];
  assign duty_w_o = duty_q[2];
  assign sector_o = sec4_q;
  assign ovm_o    = ovm4_q;

endmodule

// ----- rtl/core/space_vector_pwm_duty.sv -----
// Channel  Dir  Payload                                          Handshake
// in_i     in   angle, d_cmd, q_cmd                              valid / ready
// out_o    out  duty_u, duty_v, duty_w, sector_num, overmodulated valid / ready
//
// Command words become duty words at one word per cycle while out_o.ready stays high.
// The 11-stage register pipeline (table read, Park products, rounding, squares,
// sector, times, duties) carries each word; every stage holds a valid bit.
// rst_ni clears the valid bits only; the sine table is constant logic, no fill pass.
// Each stage loads when it is empty or the next one moves, so a stalled output
// fills the bubbles behind it before in_i.ready drops.

`include "space_vector_pwm_duty_macros.svh"

module space_vector_pwm_duty #(
  parameter int ANGLE_BITS       = 16,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int DATA_BITS        = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  svpd_in_if.sink    in_i,
  svpd_out_if.source out_o
);
  import svpd_pkg::*;

  localparam int F = DATA_BITS - 1;
  localparam logic [DATA_BITS-1:0] DUTY_FULL = DATA_BITS'(1) << F;

  // lookup -> park
  logic                        lut_valid, lut_ready;
  logic signed [DATA_BITS:0]   lut_sin, lut_cos;
  logic signed [DATA_BITS-1:0] lut_d, lut_q;

  // park -> sector
  logic                        park_valid, park_ready;
  logic signed [DATA_BITS+1:0] park_alpha, park_beta;

  // sector -> duty
  logic                         sec_valid, sec_ready;
  logic [2:0]                   sec_num;
  logic signed [DATA_BITS+33:0] sec_p;
  logic signed [DATA_BITS+1:0]  sec_beta;

  svpd_sine_lut #(
    .ANGLE_BITS       (ANGLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .DATA_BITS        (DATA_BITS)
  ) u_lut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .angle_i (in_i.angle),
    .d_i     (in_i.d_cmd),
    .q_i     (in_i.q_cmd),
    .valid_o (lut_valid),
    .ready_i (lut_ready),
    .sin_o   (lut_sin),
    .cos_o   (lut_cos),
    .d_o     (lut_d),
    .q_o     (lut_q)
  );

  // inverse Park, products rounded to Q(F) half away from zero
  svpd_park #(
    .DATA_BITS (DATA_BITS)
  ) u_park (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lut_valid),
    .ready_o (lut_ready),
    .sin_i   (lut_sin),
    .cos_i   (lut_cos),
    .d_i     (lut_d),
    .q_i     (lut_q),
    .valid_o (park_valid),
    .ready_i (park_ready),
    .alpha_o (park_alpha),
    .beta_o  (park_beta)
  );

  // sector from beta > 0, beta^2 > 3 alpha^2, alpha > 0
  svpd_sector #(
    .DATA_BITS (DATA_BITS)
  ) u_sector (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (park_valid),
    .ready_o  (park_ready),
    .alpha_i  (park_alpha),
    .beta_i   (park_beta),
    .valid_o  (sec_valid),
    .ready_i  (sec_ready),
    .sector_o (sec_num),
    .p_o      (sec_p),
    .beta_o   (sec_beta)
  );

  // t_m, t_n, t_0 and centered duties; last stage is the output register
  svpd_duty #(
    .DATA_BITS (DATA_BITS)
  ) u_duty (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sec_valid),
    .ready_o  (sec_ready),
    .sector_i (sec_num),
    .p_i      (sec_p),
    .beta_i   (sec_beta),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .duty_u_o (out_o.duty_u),
    .duty_v_o (out_o.duty_v),
    .duty_w_o (out_o.duty_w),
    .sector_o (out_o.sector_num),
    .ovm_o    (out_o.overmodulated)
  );

  `SVPD_ASSERT(a_sector_range, out_o.valid |-> (out_o.sector_num >= SECTOR_MIN && out_o.sector_num <= SECTOR_MAX), "sector out of range")
  `SVPD_ASSERT(a_duty_clamped, out_o.valid |-> (out_o.duty_u <= DUTY_FULL && out_o.duty_v <= DUTY_FULL && out_o.duty_w <= DUTY_FULL), "duty above full scale")
  `SVPD_ASSERT(a_ovm_full_phase, (out_o.valid && out_o.overmodulated) |-> (out_o.duty_u == DUTY_FULL || out_o.duty_v == DUTY_FULL || out_o.duty_w == DUTY_FULL), "overmodulated without a full phase")

endmodule
